// ===== hw/rtl/sha_pkg.sv =====
// SHA-256 byte stream hasher: shared types, constants and round functions.
// Used by sha_core and sha256_byte_stream_hasher_unit. No dependencies.
package sha_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_ADD
    } t_core_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } t_top_st;

    localparam logic [7:0][31:0] H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word ssig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word ch(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word maj(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/sha_core.sv =====
// SHA-256 compression core: one round per cycle, rolling 16-word schedule.
// Holds the hash words. Depends on sha_pkg.
module sha_core
    import sha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_core_ctl        i_ctl,
    input  logic [511:0]     i_block,
    output logic             o_done,
    output logic [7:0][31:0] o_hash
);

    t_core_st         r_st, n_st;
    logic [5:0]       r_rnd;
    logic [15:0][31:0] r_w;
    logic [7:0][31:0] r_v;
    logic [7:0][31:0] r_hash;

    t_word w_new, t1, t2;

    assign w_new = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    assign t1    = r_v[7] + bsig1(r_v[4]) + ch(r_v[4], r_v[5], r_v[6])
                 + round_k(r_rnd) + r_w[0];
    assign t2    = bsig0(r_v[0]) + maj(r_v[0], r_v[1], r_v[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= CORE_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st   = r_st;
        o_done = 1'b0;
        case (r_st)
            CORE_IDLE: begin
                if (i_ctl.start) begin
                    n_st = CORE_RUN;
                end
            end
            CORE_RUN: begin
                if (r_rnd == LAST_RND) begin
                    n_st = CORE_ADD;
                end
            end
            CORE_ADD: begin
                o_done = 1'b1;
                n_st   = CORE_IDLE;
            end
            default: begin
                n_st = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd  <= '0;
            r_hash <= H_INIT;
        end else begin
            if (r_st == CORE_RUN) begin
                r_rnd <= r_rnd + 6'd1;
            end else begin
                r_rnd <= '0;
            end
            if (i_ctl.init) begin
                r_hash <= H_INIT;
            end else if (r_st == CORE_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_v[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == CORE_IDLE && i_ctl.start) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
            r_v <= r_hash;
        end else if (r_st == CORE_RUN) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_hash = r_hash;

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 byte stream hasher top level: byte packing, padding sequencer, digest output.
// Item without end mark: shifted in; if it completes a 64-byte block, input waits for
// that block's compression. End of message: padding shifts one byte per cycle plus one
// or two compressions.
// Digest: eight result items, one per cycle while accepted. Reset is synchronous,
// active low, and returns the hash words to the initial values with empty counters.
module sha256_byte_stream_hasher_unit
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_top_st      r_st, n_st;
    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_cnt, n_cnt;
    logic [63:0]  r_bits, n_bits;
    logic         r_fin, n_fin;
    logic         r_p80, n_p80;
    logic         r_lenin, n_lenin;
    logic         r_start, n_start;
    logic [2:0]   r_wcnt, n_wcnt;

    logic             shift_en;
    logic [7:0]       shift_byte;
    logic [63:0]      len_sh;
    logic             core_done;
    logic [7:0][31:0] core_hash;
    t_core_ctl        core_ctl;

    assign len_sh = r_bits >> {~r_cnt[2:0], 3'b000};

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_block (r_blk),
        .o_done  (core_done),
        .o_hash  (core_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_fin   <= 1'b0;
            r_p80   <= 1'b0;
            r_lenin <= 1'b0;
            r_start <= 1'b0;
            r_wcnt  <= '0;
        end else begin
            r_st    <= n_st;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
            r_fin   <= n_fin;
            r_p80   <= n_p80;
            r_lenin <= n_lenin;
            r_start <= n_start;
            r_wcnt  <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

    always_comb begin
        n_st          = r_st;
        n_cnt         = r_cnt;
        n_bits        = r_bits;
        n_fin         = r_fin;
        n_p80         = r_p80;
        n_lenin       = r_lenin;
        n_start       = 1'b0;
        n_wcnt        = r_wcnt;
        shift_en      = 1'b0;
        shift_byte    = i_in_item.data_byte;
        core_ctl      = '0;
        core_ctl.start = r_start;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        case (r_st)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_item.byte_valid) begin
                        shift_en = 1'b1;
                        n_cnt    = r_cnt + 6'd1;
                        n_bits   = r_bits + 64'd8;
                    end
                    if (i_in_item.end_of_message) begin
                        n_fin = 1'b1;
                    end
                    if (i_in_item.byte_valid && r_cnt == LAST_BYTE) begin
                        n_st    = ST_COMP;
                        n_start = 1'b1;
                    end else if (i_in_item.end_of_message) begin
                        n_st = ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (core_done) begin
                    if (!r_fin) begin
                        n_st = ST_IDLE;
                    end else if (r_lenin) begin
                        n_st = ST_OUT;
                    end else begin
                        n_st = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                shift_en   = 1'b1;
                shift_byte = r_p80 ? 8'h00 : PAD_BYTE;
                n_p80      = 1'b1;
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == LAST_BYTE) begin
                    n_st    = ST_COMP;
                    n_start = 1'b1;
                end else if (r_cnt == LEN_POS - 6'd1) begin
                    n_st = ST_LEN;
                end
            end
            ST_LEN: begin
                shift_en   = 1'b1;
                shift_byte = len_sh[7:0];
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt == LAST_BYTE) begin
                    n_lenin = 1'b1;
                    n_st    = ST_COMP;
                    n_start = 1'b1;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_wcnt = r_wcnt + 3'd1;
                    if (r_wcnt == LAST_WORD) begin
                        core_ctl.init = 1'b1;
                        n_fin   = 1'b0;
                        n_p80   = 1'b0;
                        n_lenin = 1'b0;
                        n_bits  = '0;
                        n_st    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
        n_blk = shift_en ? {r_blk[503:0], shift_byte} : r_blk;
    end

    assign o_out_item.digest_word = core_hash[r_wcnt];
    assign o_out_item.word_number = r_wcnt;
    assign o_out_item.last_word   = (r_wcnt == LAST_WORD);

endmodule
